/* rtl/core/i2cm_pkg.sv */
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int unsigned LEN_W   = 10;
  localparam int unsigned PHASE_W = 5;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(10);

  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_SEND  = 3'd3,
    OP_RECV  = 3'd4,
    OP_SACK  = 3'd5,
    OP_RACK  = 3'd6,
    OP_NONE  = 3'd7
  } op_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] data_byte;
    logic       ack_bit;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       rx_ack;
    logic       rejected;
  } res_t;

  function automatic logic [PHASE_W-1:0] phase_count(input op_t op);
    logic [PHASE_W-1:0] n;
    case (op)
      OP_START: n = PHASE_W'(4);
      OP_STOP:  n = PHASE_W'(3);
      OP_SEND:  n = PHASE_W'(24);
      OP_RECV:  n = PHASE_W'(25);
      OP_SACK:  n = PHASE_W'(3);
      OP_RACK:  n = PHASE_W'(4);
      default:  n = '0;
    endcase
    return n;
  endfunction

endpackage

/* rtl/core/i2c_master_bit_sequencer.sv */
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// I2C master pin sequencer at byte level, one result per item.
// ----------------------------------------------------------------------------
// Commands (start, stop, send byte, receive byte, send ack, receive ack) are
// taken only while idle; tick items step the pin sequence, each phase held for
// phase_length ticks (0 acts as 1). A command arriving while busy is flagged
// in rejected and counts as a tick. Every item gives one result carrying the
// SCL/SDA levels after that item. Items pass through the input register, then
// the result register behind the sequencer update, and one item is taken
// every cycle while the output is not stalled. Write phase_length only while
// no item is in flight.
module i2c_master_bit_sequencer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [i2cm_pkg::LEN_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 action,
  input  logic [7:0]                 data_byte,
  input  logic                       ack_bit,
  input  logic                       sda_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       scl_level,
  output logic                       sda_level,
  output logic                       busy_res,
  output logic                       done_res,
  output logic [7:0]                 rx_byte,
  output logic                       rx_ack,
  output logic                       rejected
);

  logic [i2cm_pkg::LEN_W-1:0] phase_length;
  i2cm_pkg::item_t            in_item;
  i2cm_pkg::item_t            held_item;
  logic                       held_valid;
  logic                       held_take;
  i2cm_pkg::res_t             res;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_length <= i2cm_pkg::LEN_RESET;
    end else if (cfg_wr_en) begin
      phase_length <= cfg_wr_data;
    end
  end

  assign in_item.action    = action;
  assign in_item.data_byte = data_byte;
  assign in_item.ack_bit   = ack_bit;
  assign in_item.sda_in    = sda_in;

  i2cm_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_take  (held_take),
    .held_item  (held_item)
  );

  i2cm_core u_core (
    .clk          (clk),
    .rst          (rst),
    .phase_length (phase_length),
    .item_valid   (held_valid),
    .item_take    (held_take),
    .item         (held_item),
    .res_valid    (out_valid),
    .res_stall    (out_stall),
    .res          (res)
  );

  assign scl_level = res.scl_level;
  assign sda_level = res.sda_level;
  assign busy_res  = res.busy_res;
  assign done_res  = res.done_res;
  assign rx_byte   = res.rx_byte;
  assign rx_ack    = res.rx_ack;
  assign rejected  = res.rejected;

endmodule

/* rtl/core/i2cm_in_reg.sv */
// ----------------------------------------------------------------------------
// i2cm_in_reg
// Input register stage: holds one item until the sequencer core takes it.
// ----------------------------------------------------------------------------
module i2cm_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  i2cm_pkg::item_t in_item,
  output logic            held_valid,
  input  logic            held_take,
  output i2cm_pkg::item_t held_item
);

  logic            valid;
  i2cm_pkg::item_t item;

  assign in_stall   = valid && !held_take;
  assign held_valid = valid;
  assign held_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!in_stall) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item <= in_item;
    end
  end

endmodule

/* rtl/core/i2cm_core.sv */
// ----------------------------------------------------------------------------
// i2cm_core
// Phase sequencer state, pin registers and the result register.
// ----------------------------------------------------------------------------
module i2cm_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [i2cm_pkg::LEN_W-1:0]   phase_length,
  input  logic                         item_valid,
  output logic                         item_take,
  input  i2cm_pkg::item_t              item,
  output logic                         res_valid,
  input  logic                         res_stall,
  output i2cm_pkg::res_t               res
);

  i2cm_pkg::op_t                     op, op_next;
  logic [i2cm_pkg::PHASE_W-1:0]      phase, phase_next;
  logic [1:0]                        sub, sub_next;
  logic [i2cm_pkg::LEN_W-1:0]        wait_count, wait_count_next;
  logic [7:0]                        shift_byte, shift_byte_next;
  logic                              scl_reg, scl_reg_next;
  logic                              sda_reg, sda_reg_next;
  logic                              ack_reg, ack_reg_next;
  logic [7:0]                        rx_hold, rx_hold_next;
  logic                              ack_hold, ack_hold_next;
  logic                              done, rej;

  logic                              out_valid;
  i2cm_pkg::res_t                    out_res;

  logic [i2cm_pkg::LEN_W-1:0]        hold;
  logic [i2cm_pkg::LEN_W-1:0]        wait_dec;
  logic                              is_cmd;
  logic                              run;
  logic [1:0]                        rsub;

  assign item_take = item_valid && (!out_valid || !res_stall);
  assign res_valid = out_valid;
  assign res       = out_res;

  assign hold   = (phase_length == '0) ? i2cm_pkg::LEN_W'(1) : phase_length;
  assign is_cmd = (item.action >= i2cm_pkg::OP_START) && (item.action <= i2cm_pkg::OP_RACK);
  assign wait_dec = (wait_count != '0) ? wait_count - i2cm_pkg::LEN_W'(1) : wait_count;

  always_comb begin
    op_next         = op;
    phase_next      = phase;
    sub_next        = sub;
    wait_count_next = wait_count;
    shift_byte_next = shift_byte;
    scl_reg_next    = scl_reg;
    sda_reg_next    = sda_reg;
    ack_reg_next    = ack_reg;
    rx_hold_next    = rx_hold;
    ack_hold_next   = ack_hold;
    done            = 1'b0;
    rej             = 1'b0;
    run             = 1'b0;
    rsub            = 2'd0;

    if (op != i2cm_pkg::OP_IDLE) begin
      rej             = is_cmd;
      wait_count_next = wait_dec;
      if (wait_dec == '0) begin
        phase_next = phase + i2cm_pkg::PHASE_W'(1);
        sub_next   = (sub == 2'd2) ? 2'd0 : sub + 2'd1;
        if (phase_next >= i2cm_pkg::phase_count(op)) begin
          if (op == i2cm_pkg::OP_RECV) begin
            rx_hold_next = shift_byte;
          end
          op_next    = i2cm_pkg::OP_IDLE;
          phase_next = '0;
          sub_next   = 2'd0;
          done       = 1'b1;
        end else begin
          run = 1'b1;
        end
      end
    end else if (is_cmd) begin
      op_next         = i2cm_pkg::op_t'(item.action);
      phase_next      = '0;
      sub_next        = 2'd0;
      ack_hold_next   = item.ack_bit;
      shift_byte_next = (op_next == i2cm_pkg::OP_SEND) ? item.data_byte : 8'h00;
      run             = 1'b1;
    end

    // receive byte phases are offset by one against the mod-3 count
    case (sub_next)
      2'd0:    rsub = 2'd2;
      2'd1:    rsub = 2'd0;
      default: rsub = 2'd1;
    endcase

    if (run) begin
      wait_count_next = hold;
      case (op_next)
        i2cm_pkg::OP_START: begin
          case (phase_next)
            5'd0:    scl_reg_next = 1'b1;
            5'd1:    sda_reg_next = 1'b1;
            5'd2:    sda_reg_next = 1'b0;
            default: scl_reg_next = 1'b0;
          endcase
        end
        i2cm_pkg::OP_STOP: begin
          case (phase_next)
            5'd0:    sda_reg_next = 1'b0;
            5'd1:    scl_reg_next = 1'b1;
            default: sda_reg_next = 1'b1;
          endcase
        end
        i2cm_pkg::OP_SEND: begin
          case (sub_next)
            2'd0: begin
              sda_reg_next    = shift_byte_next[7];
              shift_byte_next = {shift_byte_next[6:0], 1'b0};
            end
            2'd1:    scl_reg_next = 1'b1;
            default: scl_reg_next = 1'b0;
          endcase
        end
        i2cm_pkg::OP_RECV: begin
          if (phase_next == '0) begin
            sda_reg_next = 1'b1;
          end else begin
            case (rsub)
              2'd0:    scl_reg_next = 1'b1;
              2'd1:    shift_byte_next = {shift_byte_next[6:0], item.sda_in};
              default: scl_reg_next = 1'b0;
            endcase
          end
        end
        i2cm_pkg::OP_SACK: begin
          case (phase_next)
            5'd0:    sda_reg_next = ack_hold_next;
            5'd1:    scl_reg_next = 1'b1;
            default: scl_reg_next = 1'b0;
          endcase
        end
        i2cm_pkg::OP_RACK: begin
          case (phase_next)
            5'd0:    sda_reg_next = 1'b1;
            5'd1:    scl_reg_next = 1'b1;
            5'd2:    ack_reg_next = item.sda_in;
            default: scl_reg_next = 1'b0;
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op         <= i2cm_pkg::OP_IDLE;
      phase      <= '0;
      sub        <= 2'd0;
      wait_count <= '0;
      shift_byte <= 8'h00;
      scl_reg    <= 1'b1;
      sda_reg    <= 1'b1;
      ack_reg    <= 1'b0;
      rx_hold    <= 8'h00;
      ack_hold   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (item_take) begin
        op         <= op_next;
        phase      <= phase_next;
        sub        <= sub_next;
        wait_count <= wait_count_next;
        shift_byte <= shift_byte_next;
        scl_reg    <= scl_reg_next;
        sda_reg    <= sda_reg_next;
        ack_reg    <= ack_reg_next;
        rx_hold    <= rx_hold_next;
        ack_hold   <= ack_hold_next;
      end
      if (item_take) begin
        out_valid <= 1'b1;
      end else if (!res_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      out_res.scl_level <= scl_reg_next;
      out_res.sda_level <= sda_reg_next;
      out_res.busy_res  <= (op_next != i2cm_pkg::OP_IDLE);
      out_res.done_res  <= done;
      out_res.rx_byte   <= rx_hold_next;
      out_res.rx_ack    <= ack_reg_next;
      out_res.rejected  <= rej;
    end
  end

endmodule

/* dv/i2c_seq_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_seq_checker
// Watches the item channels of the I2C bit sequencer, models the pin sequence
// and compares every result item, field by field, with the modelled levels.
// ----------------------------------------------------------------------------
module i2c_seq_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [i2cm_pkg::LEN_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [2:0]                 action,
  input  logic [7:0]                 data_byte,
  input  logic                       ack_bit,
  input  logic                       sda_in,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic                       scl_level,
  input  logic                       sda_level,
  input  logic                       busy_res,
  input  logic                       done_res,
  input  logic [7:0]                 rx_byte,
  input  logic                       rx_ack,
  input  logic                       rejected,
  output int                         errors,
  output int                         pending,
  output int                         checked,
  output int                         finished,
  output int                         refused
);

  // modelled sequencer state
  logic [i2cm_pkg::LEN_W-1:0]   phase_len;
  i2cm_pkg::op_t                cur_op;
  logic [i2cm_pkg::PHASE_W-1:0] phase_idx;
  logic [i2cm_pkg::LEN_W-1:0]   wait_cnt;
  logic [7:0]                   shifter;
  logic                         scl_q, sda_q, ack_q, ack_hold;
  logic [7:0]                   rx_hold;

  i2cm_pkg::res_t expected_pins[$];

  function automatic int steps_of(input i2cm_pkg::op_t op);
    case (op)
      i2cm_pkg::OP_START: return 4;
      i2cm_pkg::OP_STOP:  return 3;
      i2cm_pkg::OP_SEND:  return 24;
      i2cm_pkg::OP_RECV:  return 25;
      i2cm_pkg::OP_SACK:  return 3;
      i2cm_pkg::OP_RACK:  return 4;
      default:            return 0;
    endcase
  endfunction

  function automatic logic [i2cm_pkg::LEN_W-1:0] hold_len();
    return (phase_len == '0) ? i2cm_pkg::LEN_W'(1) : phase_len;
  endfunction

  function automatic void apply_phase(input logic line);
    int sub;
    case (cur_op)
      i2cm_pkg::OP_START: begin
        case (phase_idx)
          0:       scl_q = 1'b1;
          1:       sda_q = 1'b1;
          2:       sda_q = 1'b0;
          default: scl_q = 1'b0;
        endcase
      end
      i2cm_pkg::OP_STOP: begin
        case (phase_idx)
          0:       sda_q = 1'b0;
          1:       scl_q = 1'b1;
          default: sda_q = 1'b1;
        endcase
      end
      i2cm_pkg::OP_SEND: begin
        sub = phase_idx % 3;
        if (sub == 0) begin
          sda_q   = shifter[7];
          shifter = {shifter[6:0], 1'b0};
        end else if (sub == 1) begin
          scl_q = 1'b1;
        end else begin
          scl_q = 1'b0;
        end
      end
      i2cm_pkg::OP_RECV: begin
        if (phase_idx == 0) begin
          sda_q = 1'b1;
        end else begin
          sub = (phase_idx - 1) % 3;
          if (sub == 0) scl_q = 1'b1;
          else if (sub == 1) shifter = {shifter[6:0], line};
          else scl_q = 1'b0;
        end
      end
      i2cm_pkg::OP_SACK: begin
        case (phase_idx)
          0:       sda_q = ack_hold;
          1:       scl_q = 1'b1;
          default: scl_q = 1'b0;
        endcase
      end
      i2cm_pkg::OP_RACK: begin
        case (phase_idx)
          0:       sda_q = 1'b1;
          1:       scl_q = 1'b1;
          2:       ack_q = line;
          default: scl_q = 1'b0;
        endcase
      end
      default: ;
    endcase
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    i2cm_pkg::res_t want;
    logic is_cmd, rej, done;
    if (rst) begin
      phase_len = i2cm_pkg::LEN_RESET;
      cur_op    = i2cm_pkg::OP_IDLE;
      phase_idx = '0;
      wait_cnt  = '0;
      shifter   = '0;
      scl_q     = 1'b1;
      sda_q     = 1'b1;
      ack_q     = 1'b0;
      ack_hold  = 1'b0;
      rx_hold   = '0;
      expected_pins.delete();
      errors    = 0;
      pending   = 0;
      checked   = 0;
      finished  = 0;
      refused   = 0;
    end else begin
      if (cfg_wr_en) phase_len = cfg_wr_data;

      if (out_valid && !out_stall) begin
        if (expected_pins.size() == 0) begin
          $error("result item with no item outstanding");
          errors++;
        end else begin
          want = expected_pins.pop_front();
          check_field("scl_level", want.scl_level, scl_level);
          check_field("sda_level", want.sda_level, sda_level);
          check_field("busy_res",  want.busy_res,  busy_res);
          check_field("done_res",  want.done_res,  done_res);
          check_field("rx_byte",   want.rx_byte,   rx_byte);
          check_field("rx_ack",    want.rx_ack,    rx_ack);
          check_field("rejected",  want.rejected,  rejected);
          checked++;
        end
      end

      if (in_valid && !in_stall) begin
        is_cmd = (action >= i2cm_pkg::OP_START) && (action <= i2cm_pkg::OP_RACK);
        rej    = 1'b0;
        done   = 1'b0;
        if (cur_op != i2cm_pkg::OP_IDLE) begin
          // any item while busy acts as a tick
          rej = is_cmd;
          if (wait_cnt != '0) wait_cnt--;
          if (wait_cnt == '0) begin
            phase_idx = phase_idx + 1'b1;
            if (phase_idx >= steps_of(cur_op)) begin
              if (cur_op == i2cm_pkg::OP_RECV) rx_hold = shifter;
              cur_op    = i2cm_pkg::OP_IDLE;
              phase_idx = '0;
              done      = 1'b1;
            end else begin
              apply_phase(sda_in);
              wait_cnt = hold_len();
            end
          end
        end else if (is_cmd) begin
          cur_op    = i2cm_pkg::op_t'(action);
          phase_idx = '0;
          ack_hold  = ack_bit;
          shifter   = (cur_op == i2cm_pkg::OP_SEND) ? data_byte : 8'h00;
          apply_phase(sda_in);
          wait_cnt  = hold_len();
        end
        want.scl_level = scl_q;
        want.sda_level = sda_q;
        want.busy_res  = (cur_op != i2cm_pkg::OP_IDLE);
        want.done_res  = done;
        want.rx_byte   = rx_hold;
        want.rx_ack    = ack_q;
        want.rejected  = rej;
        expected_pins.push_back(want);
        finished += done;
        refused  += rej;
      end
      pending = expected_pins.size();
    end
  end

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Top level for the I2C bit sequencer: drives command sequences with tick
// streams, random gaps and stalls, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;

  localparam int STUCK_LIMIT = 1000;

  logic                       clk;
  logic                       rst;
  logic                       cfg_wr_en;
  logic [i2cm_pkg::LEN_W-1:0] cfg_wr_data;
  logic                       in_valid;
  logic                       in_stall;
  logic [2:0]                 action;
  logic [7:0]                 data_byte;
  logic                       ack_bit;
  logic                       sda_in;
  logic                       out_valid;
  logic                       out_stall;
  logic                       scl_level;
  logic                       sda_level;
  logic                       busy_res;
  logic                       done_res;
  logic [7:0]                 rx_byte;
  logic                       rx_ack;
  logic                       rejected;

  bit calm;
  bit long_hold;
  int fed;
  int cur_len;
  int stuck;
  int errors, pending, checked, finished, refused;

  i2c_master_bit_sequencer dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .data_byte   (data_byte),
    .ack_bit     (ack_bit),
    .sda_in      (sda_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .scl_level   (scl_level),
    .sda_level   (sda_level),
    .busy_res    (busy_res),
    .done_res    (done_res),
    .rx_byte     (rx_byte),
    .rx_ack      (rx_ack),
    .rejected    (rejected)
  );

  i2c_seq_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .data_byte   (data_byte),
    .ack_bit     (ack_bit),
    .sda_in      (sda_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .scl_level   (scl_level),
    .sda_level   (sda_level),
    .busy_res    (busy_res),
    .done_res    (done_res),
    .rx_byte     (rx_byte),
    .rx_ack      (rx_ack),
    .rejected    (rejected),
    .errors      (errors),
    .pending     (pending),
    .checked     (checked),
    .finished    (finished),
    .refused     (refused)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // receiver: short stall bursts, plus one long hold on request
  initial begin
    bit held;
    held      = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold && !held) begin
        held      = 1'b1;
        out_stall = 1'b1;
        repeat (80) @(negedge clk);
        out_stall = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck >= STUCK_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", STUCK_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic push_item(input logic [2:0] a, input logic [7:0] d, input logic k,
                           input logic s);
    if (!calm && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
    end
    @(negedge clk);
    action    = a;
    data_byte = d;
    ack_bit   = k;
    sda_in    = s;
    in_valid  = 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_len(input int v);
    drain();
    repeat (4) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = i2cm_pkg::LEN_W'(v);
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    cur_len     = v;
  endtask

  // sda_mode: bit 1 set gives a random line level, otherwise the line is held at bit 0
  task automatic run_command(input i2cm_pkg::op_t op, input logic [7:0] d, input logic k,
                             input logic [1:0] sda_mode, input bit noisy);
    int ticks;
    int r;
    logic [2:0] a;
    ticks = i2cm_pkg::phase_count(op) * ((cur_len == 0) ? 1 : cur_len);
    push_item(op, d, k, sda_mode[1] ? 1'($urandom) : sda_mode[0]);
    fed++;
    for (int i = 0; i < ticks; i++) begin
      r = noisy ? $urandom_range(0, 9) : 9;
      if (r == 0) a = 3'($urandom_range(i2cm_pkg::OP_START, i2cm_pkg::OP_RACK));
      else if (r == 1) a = i2cm_pkg::OP_NONE;
      else a = i2cm_pkg::OP_IDLE;
      push_item(a, 8'($urandom), 1'($urandom), sda_mode[1] ? 1'($urandom) : sda_mode[0]);
      fed++;
    end
  endtask

  task automatic random_commands(input int n);
    int target;
    target = fed + n;
    while (fed < target) begin
      run_command(i2cm_pkg::op_t'($urandom_range(i2cm_pkg::OP_START, i2cm_pkg::OP_RACK)),
                  8'($urandom), 1'($urandom),
                  ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 1)) : 2'd2,
                  1'($urandom));
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3))
          push_item($urandom_range(0, 1) ? i2cm_pkg::OP_IDLE : i2cm_pkg::OP_NONE,
                    8'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    action      = i2cm_pkg::OP_IDLE;
    data_byte   = '0;
    ack_bit     = 1'b0;
    sda_in      = 1'b0;
    calm        = 1'b0;
    long_hold   = 1'b0;
    fed         = 0;
    cur_len     = i2cm_pkg::LEN_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // idle ticks and the unused action leave the pins alone
    push_item(i2cm_pkg::OP_IDLE, 8'h00, 1'b0, 1'b0);
    push_item(i2cm_pkg::OP_NONE, 8'hFF, 1'b1, 1'b1);
    run_command(i2cm_pkg::OP_STOP, 8'h00, 1'b0, 2'd2, 1'b0);

    // zero length behaves as one tick per phase
    write_len(0);
    run_command(i2cm_pkg::OP_START, 8'h00, 1'b0, 2'd2, 1'b0);
    run_command(i2cm_pkg::OP_SEND,  8'hFF, 1'b0, 2'd2, 1'b0);
    run_command(i2cm_pkg::OP_SEND,  8'h00, 1'b1, 2'd2, 1'b0);
    run_command(i2cm_pkg::OP_RECV,  8'h00, 1'b0, 2'd1, 1'b0);
    run_command(i2cm_pkg::OP_RECV,  8'hFF, 1'b1, 2'd0, 1'b0);
    run_command(i2cm_pkg::OP_SACK,  8'h00, 1'b0, 2'd2, 1'b0);
    run_command(i2cm_pkg::OP_SACK,  8'h00, 1'b1, 2'd2, 1'b0);
    run_command(i2cm_pkg::OP_RACK,  8'h00, 1'b0, 2'd0, 1'b0);
    run_command(i2cm_pkg::OP_RACK,  8'h00, 1'b0, 2'd1, 1'b0);
    run_command(i2cm_pkg::OP_RECV,  8'h00, 1'b0, 2'd2, 1'b1);
    run_command(i2cm_pkg::OP_SEND,  8'h5A, 1'b0, 2'd2, 1'b1);
    run_command(i2cm_pkg::OP_STOP,  8'h00, 1'b0, 2'd2, 1'b1);
    push_item(i2cm_pkg::OP_NONE, 8'h00, 1'b0, 1'b0);

    write_len(1);
    random_commands(100);
    long_hold = 1'b1;
    random_commands(40);
    drain();
    random_commands(30);

    write_len(40);
    run_command(i2cm_pkg::OP_SACK, 8'h00, 1'b1, 2'd2, 1'b1);

    write_len(3);
    random_commands(60);
    write_len($urandom_range(1, 5));
    random_commands(50);

    // final stretch with no gaps or stalls
    write_len(2);
    calm = 1'b1;
    random_commands(60);

    drain();
    repeat (8) @(posedge clk);
    $display("Fed %0d items; %0d result items checked, %0d commands completed, %0d rejected.",
             fed, checked, finished, refused);
    $display("Phase lengths 10, 0, 1, 40, 3, 2 and one random, with a long output hold.");
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_in_reg.sv
rtl/core/i2cm_core.sv
rtl/core/i2c_master_bit_sequencer.sv
dv/i2c_seq_checker.sv
dv/tb.sv
